// ----- rtl/tfa_pkg.sv -----
// Shared types, widths and codes for the two-resource fit allocator.
`timescale 1ns / 1ps
`default_nettype none

package tfa_pkg;

  // Node table
  localparam int NODE_COUNT = 128;
  localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Field widths
  localparam int CORE_W     = 8;
  localparam int MEM_W      = 12;
  localparam int TAG_W      = 16;
  localparam int NODE_W     = 7;
  localparam int LEFT_W     = MEM_W + 1;   // cores left plus memory left
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Capacities after reset
  localparam logic [CORE_W-1:0] CORE_CAP_RESET = 8'd24;
  localparam logic [MEM_W-1:0]  MEM_CAP_RESET  = 12'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_CAP    = 2'd2;

  // Fit policies (code 3 behaves as first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Commands
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status
  localparam logic [1:0] ST_PLACED         = 2'd0;
  localparam logic [1:0] ST_NO_FIT         = 2'd1;
  localparam logic [1:0] ST_RELEASED       = 2'd2;
  localparam logic [1:0] ST_RELEASED_CLAMP = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [TAG_W-1:0]  job_tag;
    logic [CORE_W-1:0] core_demand;
    logic [MEM_W-1:0]  memory_demand;
    logic [NODE_W-1:0] release_node;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] chosen_node;
    logic [TAG_W-1:0]  result_tag;
  } result_t;

  // Free counts of one node
  typedef struct packed {
    logic [CORE_W-1:0] cores;
    logic [MEM_W-1:0]  memory;
  } node_counts_t;

  // Access to the node store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_counts_t     wr_data;
  } store_req_t;

  // Control of the fit scan
  typedef struct packed {
    logic             clear;
    logic             eval;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // Current pick of the fit scan
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  node;
    logic [CORE_W-1:0] cores_left;
    logic [MEM_W-1:0]  memory_left;
  } pick_t;

endpackage

`default_nettype wire

// ----- rtl/tfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module tfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tfa_node_store.sv -----
// Free core and memory counts per node: two RAMs plus per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module tfa_node_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tfa_pkg::store_req_t       req,
  input  wire logic                      fill_cores,
  input  wire logic                      fill_memory,
  input  wire logic [tfa_pkg::CORE_W-1:0] core_cap,
  input  wire logic [tfa_pkg::MEM_W-1:0]  mem_cap,
  output tfa_pkg::node_counts_t          rd_counts
);

  // An entry not yet written since reset or refill reads as the capacity.
  logic [tfa_pkg::NODE_COUNT-1:0] core_valid;
  logic [tfa_pkg::NODE_COUNT-1:0] memory_valid;
  logic                           core_hit;
  logic                           memory_hit;
  logic [tfa_pkg::CORE_W-1:0]     core_q;
  logic [tfa_pkg::MEM_W-1:0]      memory_q;

  tfa_ram #(
    .WIDTH (tfa_pkg::CORE_W),
    .DEPTH (tfa_pkg::NODE_COUNT)
  ) u_core_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data.cores),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (core_q)
  );

  tfa_ram #(
    .WIDTH (tfa_pkg::MEM_W),
    .DEPTH (tfa_pkg::NODE_COUNT)
  ) u_memory_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data.memory),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (memory_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      core_valid   <= '0;
      memory_valid <= '0;
    end else begin
      if (fill_cores) begin
        core_valid <= '0;
      end else if (req.wr_en) begin
        core_valid[req.wr_addr] <= 1'b1;
      end
      if (fill_memory) begin
        memory_valid <= '0;
      end else if (req.wr_en) begin
        memory_valid[req.wr_addr] <= 1'b1;
      end
    end
  end

  // Valid bits follow the RAM read latency
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      core_hit   <= core_valid[req.rd_addr];
      memory_hit <= memory_valid[req.rd_addr];
    end
  end

  assign rd_counts.cores  = core_hit   ? core_q   : core_cap;
  assign rd_counts.memory = memory_hit ? memory_q : mem_cap;

endmodule

`default_nettype wire

// ----- rtl/tfa_fit_scan.sv -----
// Fit check and running best pick over the node scan.
`timescale 1ns / 1ps
`default_nettype none

module tfa_fit_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tfa_pkg::scan_ctl_t         ctl,
  input  wire logic [1:0]                 policy,
  input  wire logic [tfa_pkg::CORE_W-1:0] core_demand,
  input  wire logic [tfa_pkg::MEM_W-1:0]  memory_demand,
  input  wire tfa_pkg::node_counts_t      counts,
  output tfa_pkg::pick_t                  pick
);

  logic                        found;
  logic [tfa_pkg::IDX_W-1:0]   pick_node;
  logic [tfa_pkg::LEFT_W-1:0]  pick_left;
  logic [tfa_pkg::CORE_W-1:0]  pick_cores;
  logic [tfa_pkg::MEM_W-1:0]   pick_memory;

  logic                        fits;
  logic [tfa_pkg::CORE_W-1:0]  core_rest;
  logic [tfa_pkg::MEM_W-1:0]   memory_rest;
  logic [tfa_pkg::LEFT_W-1:0]  left;
  logic                        better;
  logic                        take;

  always_comb begin
    fits        = (counts.cores >= core_demand) && (counts.memory >= memory_demand);
    core_rest   = counts.cores - core_demand;
    memory_rest = counts.memory - memory_demand;
    left        = tfa_pkg::LEFT_W'(core_rest) + tfa_pkg::LEFT_W'(memory_rest);
    unique case (policy)
      tfa_pkg::POL_BEST:  better = left < pick_left;
      tfa_pkg::POL_WORST: better = left > pick_left;
      default:            better = 1'b0;   // first fit keeps the lowest index
    endcase
    take = ctl.eval && fits && (!found || better);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_node   <= ctl.idx;
      pick_left   <= left;
      pick_cores  <= core_rest;
      pick_memory <= memory_rest;
    end
  end

  assign pick.found       = found;
  assign pick.node        = pick_node;
  assign pick.cores_left  = pick_cores;
  assign pick.memory_left = pick_memory;

endmodule

`default_nettype wire

// ----- rtl/two_resource_fit_allocator_core.sv -----
// Top level of the two-resource fit allocator: sequencer, registers, result.
`timescale 1ns / 1ps
`default_nettype none

// Two-resource fit allocator. Tracks free cores and free memory for
// NODE_COUNT nodes (128) held in two RAMs, one entry per node.
// A request is taken when start is high and busy is low. An allocate request
// reads every node once, one entry a cycle through the single read port, and
// keeps the best fitting node for the policy in fit_policy (first, best or
// worst fit, ties to the lowest index); it then writes the reduced counts
// back and reports the node, or reports that nothing fits. A release request
// reads the named node, adds the returned amounts, clamps each at its
// capacity and writes back. An allocate steps through the scan, drain and
// commit states, a release through the release read and write states;
// busy stays high until idle, so no new request is taken before the last
// is done. The cost of an allocate is set by the scan over the node RAM at
// one read a cycle. The result appears on result for exactly one cycle with
// done high, in the cycle after the write-back; the receiver cannot stall it
// and a new request may be started in that same cycle. Configuration writes
// are accepted whenever busy and start are both low, so a register never
// changes under a request. Writing a capacity register refills every node at
// once through per-node valid bits; there is no clearing pass.
module two_resource_fit_allocator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire tfa_pkg::request_t              request,
  // result channel
  output logic                                done,
  output tfa_pkg::result_t                    result,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfa_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,   // issue one node read per cycle
    S_DRAIN  = 6'b000100,   // evaluate the last node read
    S_COMMIT = 6'b001000,   // write back the pick, post the result
    S_REL_RD = 6'b010000,   // read the node being released to
    S_REL_WR = 6'b100000    // add, clamp, write back, post the result
  } state_t;

  state_t                       state;
  state_t                       state_next;

  // Configuration
  logic [1:0]                   fit_policy;
  logic [tfa_pkg::CORE_W-1:0]   core_cap;
  logic [tfa_pkg::MEM_W-1:0]    mem_cap;
  logic                         cfg_write;
  logic                         fill_cores;
  logic                         fill_memory;

  // Request in flight
  tfa_pkg::request_t            req;
  logic                         accept;

  // Scan pipeline: address issued, then its data evaluated in the next cycle
  logic [tfa_pkg::IDX_W-1:0]    scan_addr;
  logic                         scan_last;
  logic                         eval_pending;
  logic [tfa_pkg::IDX_W-1:0]    eval_idx;

  tfa_pkg::store_req_t          store_req;
  tfa_pkg::node_counts_t        rd_counts;
  tfa_pkg::scan_ctl_t           scan_ctl;
  tfa_pkg::pick_t               pick;

  // Release arithmetic
  logic [tfa_pkg::CORE_W:0]     rel_core_sum;
  logic [tfa_pkg::MEM_W:0]      rel_memory_sum;
  logic                         core_clamp;
  logic                         memory_clamp;
  logic                         rel_in_range;
  tfa_pkg::node_counts_t        rel_counts;

  tfa_pkg::result_t             result_next;
  logic                         post_result;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign fill_cores  = cfg_write && (cfg_index == tfa_pkg::REG_CORE_CAP);
  assign fill_memory = cfg_write && (cfg_index == tfa_pkg::REG_MEM_CAP);
  assign scan_last = (scan_addr == tfa_pkg::IDX_W'(tfa_pkg::NODE_COUNT - 1));

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= tfa_pkg::POL_FIRST;
      core_cap   <= tfa_pkg::CORE_CAP_RESET;
      mem_cap    <= tfa_pkg::MEM_CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tfa_pkg::REG_FIT_POLICY: fit_policy <= cfg_data[1:0];
        tfa_pkg::REG_CORE_CAP:   core_cap   <= cfg_data[tfa_pkg::CORE_W-1:0];
        tfa_pkg::REG_MEM_CAP:    mem_cap    <= cfg_data[tfa_pkg::MEM_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- release
  always_comb begin
    rel_core_sum   = {1'b0, rd_counts.cores}  + {1'b0, req.core_demand};
    rel_memory_sum = {1'b0, rd_counts.memory} + {1'b0, req.memory_demand};
    core_clamp     = rel_core_sum   > {1'b0, core_cap};
    memory_clamp   = rel_memory_sum > {1'b0, mem_cap};
    rel_counts.cores  = core_clamp   ? core_cap : rel_core_sum[tfa_pkg::CORE_W-1:0];
    rel_counts.memory = memory_clamp ? mem_cap  : rel_memory_sum[tfa_pkg::MEM_W-1:0];
    // nodes past the table take no state change
    rel_in_range = (32'(req.release_node) < 32'(tfa_pkg::NODE_COUNT));
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next        = state;
    store_req         = '0;
    result_next       = '0;
    post_result       = 1'b0;
    result_next.result_tag = req.job_tag;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (request.cmd == tfa_pkg::CMD_ALLOC) ? S_SCAN : S_REL_RD;
        end
      end
      S_SCAN: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = scan_addr;
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        store_req.wr_en          = pick.found;
        store_req.wr_addr        = pick.node;
        store_req.wr_data.cores  = pick.cores_left;
        store_req.wr_data.memory = pick.memory_left;
        post_result = 1'b1;
        if (pick.found) begin
          result_next.status      = tfa_pkg::ST_PLACED;
          result_next.chosen_node = tfa_pkg::NODE_W'(pick.node);
        end else begin
          result_next.status      = tfa_pkg::ST_NO_FIT;
          result_next.chosen_node = '0;
        end
        state_next = S_IDLE;
      end
      S_REL_RD: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = tfa_pkg::IDX_W'(req.release_node);
        state_next = S_REL_WR;
      end
      S_REL_WR: begin
        store_req.wr_en   = rel_in_range;
        store_req.wr_addr = tfa_pkg::IDX_W'(req.release_node);
        store_req.wr_data = rel_counts;
        post_result = 1'b1;
        result_next.chosen_node = req.release_node;
        result_next.status = (rel_in_range && (core_clamp || memory_clamp)) ?
                             tfa_pkg::ST_RELEASED_CLAMP : tfa_pkg::ST_RELEASED;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      eval_pending <= 1'b0;
    end else begin
      state        <= state_next;
      done         <= post_result;
      eval_pending <= (state == S_SCAN);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    if (accept) begin
      scan_addr <= '0;
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + 1'b1;
    end
    eval_idx <= scan_addr;
    if (post_result) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------- units
  assign scan_ctl.clear = accept;
  assign scan_ctl.eval  = eval_pending;
  assign scan_ctl.idx   = eval_idx;

  tfa_node_store u_store (
    .clk         (clk),
    .rst         (rst),
    .req         (store_req),
    .fill_cores  (fill_cores),
    .fill_memory (fill_memory),
    .core_cap    (core_cap),
    .mem_cap     (mem_cap),
    .rd_counts   (rd_counts)
  );

  tfa_fit_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .ctl           (scan_ctl),
    .policy        (fit_policy),
    .core_demand   (req.core_demand),
    .memory_demand (req.memory_demand),
    .counts        (rd_counts),
    .pick          (pick)
  );

`ifndef NO_ASSERTIONS
  // Reads and write-backs are sequenced; they never share a cycle.
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(store_req.rd_en && store_req.wr_en))
    else $error("node store read and write in the same cycle");

  // A result strobe only follows a write-back state.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_COMMIT || $past(state) == S_REL_WR))
    else $error("result strobe without a write-back");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not make the block busy");

  // Nothing fits reports node zero.
  a_no_fit_node: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == tfa_pkg::ST_NO_FIT) |-> (result.chosen_node == '0))
    else $error("no-fit result carries a node");

  // No configuration write lands while a request is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> !busy)
    else $error("configuration written while busy");
`endif

endmodule

`default_nettype wire

// ----- verif/two_resource_fit_allocator_core_tb.sv -----
// Self-checking testbench for the two-resource fit allocator core.
`timescale 1ns / 1ps

module two_resource_fit_allocator_core_tb;
  import tfa_pkg::*;

  // Run shape
  localparam int LIMIT            = 1_200_000;   // cycles before giving up
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 188;
  // idle wait at the end, longer than a whole allocate scan over the node table
  localparam int TAIL_CYCLES      = 2 * NODE_COUNT + 10;

  // Policy code 3 has no name in the package; the block treats it as first fit
  localparam logic [1:0] POL_UNUSED = 2'd3;

  // Per-phase settings: each register is rewritten each phase, both capacities
  // visit one and their top value, and the sender idling mode rotates.
  localparam logic [1:0]        PHASE_POLICY [PHASES] =
    '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_BEST, POL_WORST};
  localparam logic [CORE_W-1:0] PHASE_CORES  [PHASES] =
    '{8'd24, 8'd255, 8'd1, 8'd10, 8'd8, 8'd200};
  localparam logic [MEM_W-1:0]  PHASE_MEMORY [PHASES] =
    '{12'd64, 12'd4095, 12'd1, 12'd100, 12'd20, 12'd3000};
  localparam int                PHASE_IDLE   [PHASES] = '{0, 85, 14, 0, 85, 14};

  // Directed table. A row either writes a register or issues a request;
  // where the outcome is obvious it is typed in (given = 1), otherwise the
  // predictor supplies it.
  typedef enum logic {VEC_REQ, VEC_CFG} vec_kind_e;

  typedef struct packed {
    vec_kind_e             kind;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic                  cmd;
    logic [TAG_W-1:0]      tag;
    logic [CORE_W-1:0]     cores;
    logic [MEM_W-1:0]      memory;
    logic [NODE_W-1:0]     node;
    logic                  given;
    logic [1:0]            status;
    logic [NODE_W-1:0]     exp_node;
  } vector_t;

  localparam int DIRECTED_ROWS = 28;

  // kind, reg, data, cmd, tag, cores, memory, release node, given, status, node
  localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
    // reset state: policy first fit, 24 cores and 64 memory per node
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0000, 8'd0,   12'd0,    7'd0,
      1'b1, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'hFFFF, 8'd255, 12'd4095, 7'd127,
      1'b1, ST_NO_FIT,         7'd0},
    // drain node 0 completely, then the next request must go to node 1
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0003, 8'd24,  12'd64,   7'd0,
      1'b1, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0004, 8'd1,   12'd0,    7'd0,
      1'b1, ST_PLACED,         7'd1},
    // releases: exact refill, clamp on both counts, top node
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_RELEASE, 16'h0005, 8'd24,  12'd64,   7'd0,
      1'b1, ST_RELEASED,       7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_RELEASE, 16'h0006, 8'd255, 12'd4095, 7'd1,
      1'b1, ST_RELEASED_CLAMP, 7'd1},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_RELEASE, 16'h0007, 8'd0,   12'd0,    7'd127,
      1'b1, ST_RELEASED,       7'd127},
    // one over capacity on either resource fits nowhere; then a memory-only clamp
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0008, 8'd25,  12'd0,    7'd0,
      1'b1, ST_NO_FIT,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0009, 8'd0,   12'd65,   7'd0,
      1'b1, ST_NO_FIT,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_RELEASE, 16'h000A, 8'd0,   12'd1,    7'd5,
      1'b1, ST_RELEASED_CLAMP, 7'd5},
    // best fit: tie on an untouched table, then the already used node wins
    '{VEC_CFG, REG_FIT_POLICY, 12'(POL_BEST), CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h000B, 8'd10,  12'd10,   7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h000C, 8'd5,   12'd5,    7'd0,
      1'b0, ST_PLACED,         7'd0},
    // worst fit: the node with the most left free, lowest index on a tie
    '{VEC_CFG, REG_FIT_POLICY, 12'(POL_WORST), CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h000D, 8'd3,   12'd3,    7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h000E, 8'd0,   12'd0,    7'd0,
      1'b0, ST_PLACED,         7'd0},
    // unused policy code falls back to first fit
    '{VEC_CFG, REG_FIT_POLICY, 12'(POL_UNUSED), CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h000F, 8'd24,  12'd64,   7'd0,
      1'b0, ST_PLACED,         7'd0},
    // zero core capacity: only a zero core demand fits, any core return clamps
    '{VEC_CFG, REG_CORE_CAP,   12'd0,    CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_CFG, REG_MEM_CAP,    12'd4095, CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0010, 8'd0,   12'd4095, 7'd0,
      1'b1, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0011, 8'd1,   12'd0,    7'd0,
      1'b1, ST_NO_FIT,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_RELEASE, 16'h0012, 8'd1,   12'd0,    7'd3,
      1'b1, ST_RELEASED_CLAMP, 7'd3},
    // zero memory capacity, full core capacity
    '{VEC_CFG, REG_CORE_CAP,   12'd255,  CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_CFG, REG_MEM_CAP,    12'd0,    CMD_ALLOC, 16'h0000, 8'd0, 12'd0, 7'd0,
      1'b0, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0013, 8'd255, 12'd0,    7'd0,
      1'b1, ST_PLACED,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_ALLOC,   16'h0014, 8'd0,   12'd1,    7'd0,
      1'b1, ST_NO_FIT,         7'd0},
    '{VEC_REQ, REG_FIT_POLICY, 12'd0, CMD_RELEASE, 16'h0015, 8'd255, 12'd4095, 7'd127,
      1'b1, ST_RELEASED_CLAMP, 7'd127}
  };

  // A placement still held by a job, so that it can be handed back later
  typedef struct {
    logic [NODE_W-1:0] node;
    logic [CORE_W-1:0] cores;
    logic [MEM_W-1:0]  memory;
  } job_grant_t;

  // DUT connections; every input is known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  request_t              request   = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  done;
  logic                  cfg_ready;
  result_t               result;

  // Predictor state: its own copy of the node table and the registers
  logic [CORE_W-1:0] node_cores_free  [NODE_COUNT];
  logic [MEM_W-1:0]  node_memory_free [NODE_COUNT];
  logic [1:0]        policy_now      = POL_FIRST;
  logic [CORE_W-1:0] cores_per_node  = CORE_CAP_RESET;
  logic [MEM_W-1:0]  memory_per_node = MEM_CAP_RESET;

  result_t    pending_outcomes [$];   // oldest first
  job_grant_t live_jobs [$];
  int         sender_idle_pct = 0;
  int         mismatches      = 0;
  int         cycles_run      = 0;

  always #5 clk = ~clk;

  two_resource_fit_allocator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    foreach (node_cores_free[i]) node_cores_free[i] = CORE_CAP_RESET;
    foreach (node_memory_free[i]) node_memory_free[i] = MEM_CAP_RESET;
  end

  // Outcome of one request against the predictor's table. Updates the table.
  // First fit never replaces its first candidate, so no early exit is needed.
  function automatic result_t place_or_return(input request_t r);
    result_t    res;
    job_grant_t g;
    bit         found;
    bit         take;
    int         pick;
    int         pick_left;
    int         left;
    int         c;
    int         m;
    res.result_tag = r.job_tag;
    if (r.cmd == CMD_ALLOC) begin
      found     = 1'b0;
      pick      = 0;
      pick_left = 0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (node_cores_free[i] >= r.core_demand && node_memory_free[i] >= r.memory_demand) begin
          left = (int'(node_cores_free[i]) - int'(r.core_demand))
               + (int'(node_memory_free[i]) - int'(r.memory_demand));
          if (!found)
            take = 1'b1;
          else if (policy_now == POL_BEST)
            take = left < pick_left;
          else if (policy_now == POL_WORST)
            take = left > pick_left;
          else
            take = 1'b0;
          if (take) begin
            found     = 1'b1;
            pick      = i;
            pick_left = left;
          end
        end
      end
      if (found) begin
        node_cores_free[pick]  = node_cores_free[pick] - r.core_demand;
        node_memory_free[pick] = node_memory_free[pick] - r.memory_demand;
        res.status      = ST_PLACED;
        res.chosen_node = NODE_W'(pick);
        g.node   = NODE_W'(pick);
        g.cores  = r.core_demand;
        g.memory = r.memory_demand;
        live_jobs.insert(live_jobs.size(), g);
      end else begin
        res.status      = ST_NO_FIT;
        res.chosen_node = '0;
      end
    end else begin
      res.status      = ST_RELEASED;
      res.chosen_node = r.release_node;
      if (int'(r.release_node) < NODE_COUNT) begin
        c = int'(node_cores_free[r.release_node]) + int'(r.core_demand);
        m = int'(node_memory_free[r.release_node]) + int'(r.memory_demand);
        if (c > int'(cores_per_node)) begin
          c          = int'(cores_per_node);
          res.status = ST_RELEASED_CLAMP;
        end
        if (m > int'(memory_per_node)) begin
          m          = int'(memory_per_node);
          res.status = ST_RELEASED_CLAMP;
        end
        node_cores_free[r.release_node]  = CORE_W'(c);
        node_memory_free[r.release_node] = MEM_W'(m);
      end
    end
    return res;
  endfunction

  // Random traffic. Mostly demands sized to the current capacities and
  // returns of jobs actually placed, so the table drifts into uneven fill
  // and the policies get to disagree; the rest is oversized demands and
  // returns of arbitrary amounts to arbitrary nodes (clamp path).
  function automatic request_t next_random_request();
    request_t   r;
    job_grant_t g;
    int         sel;
    int         k;
    sel = $urandom_range(99);
    r.cmd           = CMD_ALLOC;
    r.job_tag       = TAG_W'($urandom);
    r.release_node  = NODE_W'($urandom);
    r.core_demand   = CORE_W'($urandom_range(int'(cores_per_node) / 4 + 1));
    r.memory_demand = MEM_W'($urandom_range(int'(memory_per_node) / 4 + 1));
    if (sel >= 55 && sel < 85 && live_jobs.size() != 0) begin
      k = $urandom_range(live_jobs.size() - 1);
      g = live_jobs[k];
      live_jobs.delete(k);
      r.cmd           = CMD_RELEASE;
      r.release_node  = g.node;
      r.core_demand   = g.cores;
      r.memory_demand = g.memory;
    end else if (sel >= 85 && sel < 93) begin
      r.core_demand   = CORE_W'($urandom);
      r.memory_demand = MEM_W'($urandom);
    end else if (sel >= 93) begin
      r.cmd           = CMD_RELEASE;
      r.core_demand   = CORE_W'($urandom);
      r.memory_demand = MEM_W'($urandom);
    end
    return r;
  endfunction

  // Register write on the config channel. valid is left high so that
  // back-to-back writes need no drop; the caller lowers it afterwards.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIT_POLICY: begin
        policy_now = data[1:0];
      end
      REG_CORE_CAP: begin
        cores_per_node = data[CORE_W-1:0];
        foreach (node_cores_free[i]) node_cores_free[i] = cores_per_node;
        live_jobs.delete();
      end
      REG_MEM_CAP: begin
        memory_per_node = data[MEM_W-1:0];
        foreach (node_memory_free[i]) node_memory_free[i] = memory_per_node;
        live_jobs.delete();
      end
      default: ;
    endcase
  endtask

  // One request: optional idle gap with start low, then start held until the
  // block takes it. start stays high on return so a following request can
  // go straight out without a drop within the same time step.
  task automatic issue(input request_t r, input bit given, input result_t given_outcome);
    result_t predicted;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    predicted = place_or_return(r);
    pending_outcomes.insert(pending_outcomes.size(), given ? given_outcome : predicted);
  endtask

  // Every request yields exactly one result, so once nothing is pending the
  // block is idle and registers may be written.
  task automatic finish_outstanding();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Result checker. done and result are sampled at the edge that accepts them.
  always @(posedge clk) begin : outcome_check
    result_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: status %0d node %0d tag %h",
                   $time, result.status, result.chosen_node, result.result_tag);
      end else begin
        want = pending_outcomes.pop_front();
        if (result.status !== want.status || result.chosen_node !== want.chosen_node ||
            result.result_tag !== want.result_tag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: exp status %0d node %0d tag %h, got %0d node %0d tag %h",
                     $time, want.status, want.chosen_node, want.result_tag,
                     result.status, result.chosen_node, result.result_tag);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    request_t r;
    vector_t  v;
    result_t  typed_outcome;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      v = DIRECTED[n];
      if (v.kind == VEC_CFG) begin
        finish_outstanding();
        write_register(v.cfg_idx, v.cfg_val);
      end else begin
        cfg_valid <= 1'b0;
        r.cmd                    = v.cmd;
        r.job_tag                = v.tag;
        r.core_demand            = v.cores;
        r.memory_demand          = v.memory;
        r.release_node           = v.node;
        typed_outcome.status      = v.status;
        typed_outcome.chosen_node = v.exp_node;
        typed_outcome.result_tag  = v.tag;
        issue(r, v.given, typed_outcome);
      end
    end

    // random phases: reprogram everything while idle, then a burst of traffic
    for (int ph = 0; ph < PHASES; ph++) begin
      finish_outstanding();
      write_register(REG_FIT_POLICY, CFG_DATA_W'(PHASE_POLICY[ph]));
      write_register(REG_CORE_CAP, CFG_DATA_W'(PHASE_CORES[ph]));
      write_register(REG_MEM_CAP, PHASE_MEMORY[ph]);
      cfg_valid <= 1'b0;
      sender_idle_pct = PHASE_IDLE[ph];
      repeat (RANDOM_PER_PHASE) issue(next_random_request(), 1'b0, '0);
    end

    finish_outstanding();
    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
